>>> rtl/scq_pkg.sv
// ----------------------------------------------------------------------------
// Cycle-tagged ring queue: shared package
// Sizes, slot layout, memory request format and the codes of the queue.
// ----------------------------------------------------------------------------
package scq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned RING     = 2 * CAPACITY;
  localparam int unsigned IDX_W    = $clog2(RING);
  localparam int unsigned CNT_W    = 64;
  localparam int unsigned CYC_W    = CNT_W - IDX_W;
  localparam int unsigned THR_W    = $clog2(3 * CAPACITY) + 1;
  localparam int unsigned FUNC_W   = 1;
  localparam int unsigned VAL_W    = 5;
  localparam int unsigned STAT_W   = 2;

  localparam logic [IDX_W-1:0]        EMPTY_MARK = IDX_W'(RING - 1);
  localparam logic signed [THR_W-1:0] THR_FULL   = THR_W'(3 * CAPACITY - 1);
  localparam logic signed [THR_W-1:0] THR_RESET  = THR_W'(-1);
  localparam logic [CNT_W-1:0]        CNT_RESET  = CNT_W'(RING);
  localparam logic [IDX_W-1:0]        LAST_TRY   = IDX_W'(RING - 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE     = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [CYC_W-1:0] cyc;
    logic             safe;
    logic [IDX_W-1:0] idx;
  } slot_t;

  localparam slot_t SLOT_RESET = '{cyc: '0, safe: 1'b1, idx: EMPTY_MARK};

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_t            wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] value;
  } result_t;

endpackage

>>> rtl/scq_in_if.sv
// ----------------------------------------------------------------------------
// Cycle-tagged ring queue: request channel
// Carries one request word: the operation and the index to enqueue.
// ----------------------------------------------------------------------------
interface scq_in_if;

  logic                                          valid;
  logic                                          ready;
  logic [scq_pkg::FUNC_W-1:0]                    func;
  logic [scq_pkg::VAL_W-1:0]                     value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);

endinterface

>>> rtl/scq_out_if.sv
// ----------------------------------------------------------------------------
// Cycle-tagged ring queue: response channel
// Carries one response word: the status and the dequeued index.
// ----------------------------------------------------------------------------
interface scq_out_if;

  logic                                          valid;
  logic                                          ready;
  logic [scq_pkg::STAT_W-1:0]                    status;
  logic [scq_pkg::VAL_W-1:0]                     result_value;

  modport source (output valid, output status, output result_value, input ready);
  modport sink   (input valid, input status, input result_value, output ready);

endinterface

>>> rtl/scq_slot_ram.sv
// ----------------------------------------------------------------------------
// Cycle-tagged ring queue: slot memory
// One write port and one read port with registered read data. Per-entry
// valid flops make an unwritten slot read as its reset contents.
// ----------------------------------------------------------------------------
module scq_slot_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scq_pkg::mem_req_t req_i,
  output scq_pkg::slot_t    rd_o
);

  scq_pkg::slot_t                mem_q [scq_pkg::RING];
  logic [scq_pkg::RING-1:0]      valid_q;
  scq_pkg::slot_t                rd_data_q;
  logic                          rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[req_i.raddr];
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[req_i.raddr];
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  assign rd_o = rd_valid_q ? rd_data_q : scq_pkg::SLOT_RESET;

endmodule

>>> rtl/scq_ctrl.sv
// ----------------------------------------------------------------------------
// Cycle-tagged ring queue: sequencer
// Holds the head, tail and threshold counters and walks the ring one slot
// per cycle: the slot read in one cycle is checked and written back in the
// next, while the following slot is already being read.
// ----------------------------------------------------------------------------
module scq_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [scq_pkg::FUNC_W-1:0]  in_func_i,
  input  logic [scq_pkg::VAL_W-1:0]   in_value_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output scq_pkg::result_t            res_o,
  output scq_pkg::mem_req_t           mem_req_o,
  input  scq_pkg::slot_t              slot_i
);

  scq_pkg::state_e                     state_q, state_d;
  logic [scq_pkg::CNT_W-1:0]           head_q, head_d;
  logic [scq_pkg::CNT_W-1:0]           tail_q, tail_d;
  logic signed [scq_pkg::THR_W-1:0]    thr_q, thr_d;
  logic [scq_pkg::IDX_W-1:0]           tries_q, tries_d;
  scq_pkg::func_e                      op_q, op_d;
  logic [scq_pkg::VAL_W-1:0]           val_q, val_d;
  scq_pkg::result_t                    pend_q, pend_d;

  logic [scq_pkg::CNT_W-1:0]           cur;
  logic [scq_pkg::CNT_W-1:0]           cur_p1;
  logic [scq_pkg::CYC_W-1:0]           cur_cyc;
  logic                                fin;
  scq_pkg::result_t                    fin_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scq_pkg::S_IDLE;
      head_q  <= scq_pkg::CNT_RESET;
      tail_q  <= scq_pkg::CNT_RESET;
      thr_q   <= scq_pkg::THR_RESET;
      tries_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      thr_q   <= thr_d;
      tries_q <= tries_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    val_q  <= val_d;
    pend_q <= pend_d;
  end

  assign cur     = (op_q == scq_pkg::FUNC_DEQ) ? head_q : tail_q;
  assign cur_p1  = cur + scq_pkg::CNT_W'(1);
  assign cur_cyc = cur[scq_pkg::CNT_W-1:scq_pkg::IDX_W];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    thr_d       = thr_q;
    tries_d     = tries_q;
    op_d        = op_q;
    val_d       = val_q;
    pend_d      = pend_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = pend_q;
    fin         = 1'b0;
    fin_res     = '{status: scq_pkg::STAT_DONE, value: '0};
    mem_req_o   = '{we: 1'b0, waddr: cur[scq_pkg::IDX_W-1:0], wdata: slot_i,
                    raddr: cur_p1[scq_pkg::IDX_W-1:0]};

    case (state_q)
      scq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        mem_req_o.raddr = (scq_pkg::func_e'(in_func_i) == scq_pkg::FUNC_DEQ) ?
                          head_q[scq_pkg::IDX_W-1:0] : tail_q[scq_pkg::IDX_W-1:0];
        if (in_valid_i) begin
          op_d    = scq_pkg::func_e'(in_func_i);
          val_d   = in_value_i;
          tries_d = '0;
          if (scq_pkg::func_e'(in_func_i) == scq_pkg::FUNC_DEQ &&
              thr_q[scq_pkg::THR_W-1]) begin
            fin            = 1'b1;
            fin_res.status = scq_pkg::STAT_EMPTY;
          end else begin
            state_d = scq_pkg::S_EVAL;
          end
        end
      end
      scq_pkg::S_EVAL: begin
        if (op_q == scq_pkg::FUNC_ENQ) begin
          tail_d = cur_p1;
          if (slot_i.cyc < cur_cyc && slot_i.idx == scq_pkg::EMPTY_MARK &&
              (slot_i.safe || head_q <= cur)) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.wdata = '{cyc: cur_cyc, safe: 1'b1,
                                idx: scq_pkg::IDX_W'(val_q)};
            thr_d           = scq_pkg::THR_FULL;
            fin             = 1'b1;
          end else if (tries_q == scq_pkg::LAST_TRY) begin
            fin            = 1'b1;
            fin_res.status = scq_pkg::STAT_OVERFLOW;
          end else begin
            tries_d = tries_q + scq_pkg::IDX_W'(1);
          end
        end else begin
          head_d = cur_p1;
          if (slot_i.cyc == cur_cyc) begin
            mem_req_o.we        = 1'b1;
            mem_req_o.wdata.idx = scq_pkg::EMPTY_MARK;
            fin                 = 1'b1;
            fin_res.value       = scq_pkg::VAL_W'(slot_i.idx);
          end else begin
            if (slot_i.cyc < cur_cyc) begin
              mem_req_o.we = 1'b1;
              if (slot_i.idx == scq_pkg::EMPTY_MARK) begin
                mem_req_o.wdata.cyc = cur_cyc;
              end else begin
                mem_req_o.wdata.safe = 1'b0;
              end
            end
            thr_d = thr_q - scq_pkg::THR_W'(1);
            if (tail_q <= cur_p1) begin
              tail_d         = cur_p1;
              fin            = 1'b1;
              fin_res.status = scq_pkg::STAT_EMPTY;
            end else if (thr_q[scq_pkg::THR_W-1] || thr_q == '0) begin
              fin            = 1'b1;
              fin_res.status = scq_pkg::STAT_EMPTY;
            end
          end
        end
      end
      scq_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = scq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = scq_pkg::S_IDLE;
      end
    endcase

    if (fin) begin
      res_valid_o = 1'b1;
      res_o       = fin_res;
      if (res_ready_i) begin
        state_d = scq_pkg::S_IDLE;
      end else begin
        pend_d  = fin_res;
        state_d = scq_pkg::S_RESP;
      end
    end
  end

  // The ring is only written while a slot is being checked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> state_q == scq_pkg::S_EVAL)
    else $error("slot write outside of slot check");

  // A walk that continues reads the next slot, never the one being written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we && state_d == scq_pkg::S_EVAL) |-> mem_req_o.waddr != mem_req_o.raddr)
    else $error("read and write of the same slot in one cycle");

  // The threshold never drops below minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_q >= scq_pkg::THR_RESET)
    else $error("threshold below minus one");

  // The head only ever steps forward by one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q != $past(head_q) |-> head_q == $past(head_q) + scq_pkg::CNT_W'(1))
    else $error("head counter jumped");

endmodule

>>> rtl/cycle_tagged_ring_queue_top.sv
// ----------------------------------------------------------------------------
// Cycle-tagged ring queue: top level
// Queue of small indices in a ring of cycle-tagged slots.
// ----------------------------------------------------------------------------
// Requests arrive on in_i: func selects enqueue or dequeue, value is the
// index to enqueue. Every request gives exactly one response word on out_o:
// status is done, queue empty (dequeue) or overflow (enqueue), and
// result_value holds the dequeued index on a successful dequeue, else zero.
// A request is taken only while no other request is being worked on. The
// slot memory has registered read data and the walk visits slots in turn;
// the number of slots walked is 1 when the first slot fits, up to 2*CAPACITY
// for an enqueue that overflows and up to 3*CAPACITY for a dequeue that
// runs the threshold down. A dequeue while the threshold is negative
// answers empty from the acceptance cycle with no slot access. The response
// sits in an output register; with a free receiver the sequencer is back in
// idle and accepts the next request in the cycle after the response is
// produced. When the receiver stalls, one further finished response is held
// inside and the block stops taking requests until the output register
// drains. Reset empties the queue at once: all slots read as empty with
// cycle zero, no clearing pass is needed.
// ----------------------------------------------------------------------------
module cycle_tagged_ring_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  scq_in_if.sink      in_i,
  scq_out_if.source   out_o
);

  logic                 res_valid;
  logic                 res_ready;
  scq_pkg::result_t     res;
  scq_pkg::mem_req_t    mem_req;
  scq_pkg::slot_t       slot_rd;

  logic                         out_valid_q, out_valid_d;
  logic [scq_pkg::STAT_W-1:0]   out_status_q, out_status_d;
  logic [scq_pkg::VAL_W-1:0]    out_value_q, out_value_d;

  scq_slot_ram u_scq_slot_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rd_o   (slot_rd)
  );

  scq_ctrl u_scq_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_func_i   (in_i.func),
    .in_value_i  (in_i.value),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .slot_i      (slot_rd)
  );

  assign res_ready = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_status_d = scq_pkg::STAT_W'(res.status);
        out_value_d  = res.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.result_value = out_value_q;

endmodule

>>> tb/sv/scq_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cycle-tagged ring queue: response checker
// Watches the request and response channels. Every accepted request word is
// run through a request-level model of the slot ring, head, tail and
// threshold, and the predicted response is queued. Every accepted response
// word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module scq_queue_checker
  import scq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  scq_in_if    req_mon,
  scq_out_if   rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int PRED_DEPTH = 64;

  logic [CYC_W-1:0]        ring_cyc  [RING];
  logic                    ring_safe [RING];
  logic [IDX_W-1:0]        ring_idx  [RING];
  logic [CNT_W-1:0]        head_q;
  logic [CNT_W-1:0]        tail_q;
  logic signed [THR_W-1:0] thr_q;

  result_t predicted_words [PRED_DEPTH];
  int      pred_wr;
  int      pred_rd;
  int      fails;
  int      rsp_seen;

  function automatic result_t apply_request(func_e op, logic [VAL_W-1:0] val);
    result_t                 res;
    logic [CNT_W-1:0]        pos;
    logic [IDX_W-1:0]        slot;
    logic [CYC_W-1:0]        cyc;
    logic signed [THR_W-1:0] prev;
    bit                      walking;
    int                      n;
    res.value = '0;
    if (op == FUNC_ENQ) begin
      res.status = STAT_OVERFLOW;
      for (n = 0; n < RING; n++) begin
        pos    = tail_q;
        slot   = pos[IDX_W-1:0];
        cyc    = CYC_W'(pos >> IDX_W);
        tail_q = pos + 1;
        if (ring_cyc[slot] < cyc && ring_idx[slot] == EMPTY_MARK &&
            (ring_safe[slot] || head_q <= pos)) begin
          ring_cyc[slot]  = cyc;
          ring_safe[slot] = 1'b1;
          ring_idx[slot]  = IDX_W'(val);
          thr_q           = THR_FULL;
          res.status      = STAT_DONE;
          break;
        end
      end
    end else begin
      res.status = STAT_EMPTY;
      walking    = (thr_q >= 0);
      while (walking) begin
        pos    = head_q;
        slot   = pos[IDX_W-1:0];
        cyc    = CYC_W'(pos >> IDX_W);
        head_q = pos + 1;
        if (ring_cyc[slot] == cyc) begin
          res.status     = STAT_DONE;
          res.value      = VAL_W'(ring_idx[slot]);
          ring_idx[slot] = EMPTY_MARK;
          walking        = 1'b0;
        end else begin
          if (ring_cyc[slot] < cyc) begin
            if (ring_idx[slot] == EMPTY_MARK) begin
              ring_cyc[slot] = cyc;
            end else begin
              ring_safe[slot] = 1'b0;
            end
          end
          if (tail_q <= pos + 1) begin
            tail_q  = pos + 1;
            thr_q   = thr_q - 1;
            walking = 1'b0;
          end else begin
            prev  = thr_q;
            thr_q = thr_q - 1;
            if (prev <= 0) begin
              walking = 1'b0;
            end
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < RING; k++) begin
        ring_cyc[k]  = '0;
        ring_safe[k] = 1'b1;
        ring_idx[k]  = EMPTY_MARK;
      end
      head_q = CNT_RESET;
      tail_q = CNT_RESET;
      thr_q  = THR_RESET;
      pred_wr  = 0;
      pred_rd  = 0;
      fails    = 0;
      rsp_seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        predicted_words[pred_wr % PRED_DEPTH] =
          apply_request(func_e'(req_mon.func), req_mon.value);
        pred_wr++;
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pred_wr == pred_rd) begin
          fails++;
          if (fails <= 10) begin
            $display("response %0d arrived with no request waiting: status %0d value %0d",
                     rsp_seen, rsp_mon.status, rsp_mon.result_value);
          end
        end else begin
          want = predicted_words[pred_rd % PRED_DEPTH];
          pred_rd++;
          if (rsp_mon.status !== want.status || rsp_mon.result_value !== want.value) begin
            fails++;
            if (fails <= 10) begin
              $display("mismatch on response %0d: expected status %0d value %0d,",
                       rsp_seen, want.status, want.value);
              $display("  got status %0d value %0d",
                       rsp_mon.status, rsp_mon.result_value);
            end
          end
        end
        rsp_seen++;
      end
      fail_count_o <= fails;
      pending_o    <= pred_wr - pred_rd;
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cycle-tagged ring queue: testbench top
// Drives directed and phased random enqueue and dequeue words into the queue,
// with random idling on both channels, a stretch without idling and drain
// pauses. The checker beside the block predicts and compares the responses.
// ----------------------------------------------------------------------------
module tb;
  import scq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_WORDS  = 50;
  localparam int PHASES       = 23;
  localparam int SETTLE_TICKS = 80;

  logic clk;
  logic rst_n;
  logic calm;
  int   cycles = 0;
  int   fail_count;
  int   pending;

  scq_in_if  req_w ();
  scq_out_if rsp_w ();

  cycle_tagged_ring_queue_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_w),
    .out_o  (rsp_w)
  );

  scq_queue_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_mon      (req_w),
    .rsp_mon      (rsp_w),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_w.ready <= calm || ($urandom_range(99) >= 15);
  end

  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    if ($urandom_range(19) == 0) begin
      v = EMPTY_MARK;
    end else begin
      v = VAL_W'($urandom_range(30));
    end
    return v;
  endfunction

  task automatic send_word(input func_e op, input logic [VAL_W-1:0] val);
    req_w.valid <= 1'b1;
    req_w.func  <= op;
    req_w.value <= val;
    @(posedge clk);
    while (!req_w.ready) @(posedge clk);
    if (!calm) begin
      while ($urandom_range(99) < 15) begin
        req_w.valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic drain_queue();
    req_w.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int enq_pct;
    calm        <= 1'b0;
    rst_n       <= 1'b0;
    req_w.valid <= 1'b0;
    req_w.func  <= FUNC_ENQ;
    req_w.value <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Dequeue before anything was stored, then extremes and the empty mark.
    send_word(FUNC_DEQ, 5'd0);
    send_word(FUNC_ENQ, 5'd0);
    send_word(FUNC_ENQ, 5'd30);
    send_word(FUNC_ENQ, EMPTY_MARK);
    send_word(FUNC_DEQ, 5'd31);
    send_word(FUNC_DEQ, 5'd0);
    send_word(FUNC_DEQ, 5'd0);
    // The queue is empty but the threshold is still positive: the tail
    // catches up to the head.
    send_word(FUNC_DEQ, 5'd0);
    send_word(FUNC_DEQ, 5'd0);
    send_word(FUNC_ENQ, 5'd21);
    send_word(FUNC_ENQ, 5'd10);
    send_word(FUNC_DEQ, 5'd0);
    send_word(FUNC_DEQ, 5'd0);
    send_word(FUNC_DEQ, 5'd0);
    for (int b = 0; b < VAL_W; b++) begin
      send_word(FUNC_ENQ, VAL_W'(1 << b));
    end
    for (int b = 0; b < VAL_W; b++) begin
      send_word(FUNC_DEQ, 5'd0);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       enq_pct = 85;
        1:       enq_pct = 50;
        2:       enq_pct = 15;
        default: enq_pct = $urandom_range(100);
      endcase
      if (p == 10 || p == 17) begin
        drain_queue();
      end
      calm <= (p == 5 || p == 6);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(99) < enq_pct) begin
          send_word(FUNC_ENQ, pick_value());
        end else begin
          send_word(FUNC_DEQ, VAL_W'($urandom_range(31)));
        end
      end
    end
    calm <= 1'b0;

    drain_queue();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/scq_pkg.sv
rtl/scq_in_if.sv
rtl/scq_out_if.sv
rtl/scq_slot_ram.sv
rtl/scq_ctrl.sv
rtl/cycle_tagged_ring_queue_top.sv
tb/sv/scq_queue_checker.sv
tb/sv/tb.sv
